### rtl/bitmap_index_set_defines.svh
`ifndef BITMAP_INDEX_SET_DEFINES_SVH
`define BITMAP_INDEX_SET_DEFINES_SVH

// Same-cycle implication, sampled on clk and masked while rst_n is low.
`define BIS_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bitmap_index_set: same-cycle check failed");

// Next-cycle implication, sampled on clk and masked while rst_n is low.
`define BIS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bitmap_index_set: next-cycle check failed");

`endif

### rtl/bis_pkg.sv
`timescale 1ns / 1ps

package bis_pkg;

    // Universe and bitmap word layout
    localparam int UNIVERSE = 1024;
    localparam int WORD_W   = 64;
    localparam int BIT_W    = $clog2(WORD_W);
    localparam int WORDS    = (UNIVERSE + WORD_W - 1) / WORD_W;
    localparam int WADDR_W  = (WORDS > 1) ? $clog2(WORDS) : 1;

    // Field widths
    localparam int OP_W     = 3;
    localparam int IDX_W    = 10;
    localparam int POS_W    = 12;
    localparam int HI_W     = 11;
    localparam int CNT_W    = 11;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT   = 3'd0,
        OP_REMOVE   = 3'd1,
        OP_CONTAINS = 3'd2,
        OP_NEXT     = 3'd3,
        OP_PREV     = 3'd4,
        OP_CLEAR    = 3'd5,
        OP_LOAD     = 3'd6
    } op_t;

    // Scan request from the controller to the word scanner
    typedef struct packed {
        logic             start;
        logic             up;
        logic [IDX_W-1:0] start_pos;
    } scan_cmd_t;

    // Scan answer: nearest member found in the current word
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] pos;
    } scan_res_t;

    // Bitmap word that holds an index
    function automatic logic [WADDR_W-1:0] word_of(input logic [IDX_W-1:0] i);
        return WADDR_W'(i >> BIT_W);
    endfunction

endpackage

### rtl/bis_ram.sv
`timescale 1ns / 1ps

module bis_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port, registered read port returning the old word on a collision
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/bis_scan.sv
`timescale 1ns / 1ps
`include "bitmap_index_set_defines.svh"

module bis_scan import bis_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  scan_cmd_t          cmd,
    input  logic [WORD_W-1:0]  rdata,
    output logic [WADDR_W-1:0] raddr,
    output scan_res_t          res
);

    logic               active_reg;
    logic               up_reg;
    logic               first_reg;
    logic [BIT_W-1:0]   bit_reg;
    logic [WADDR_W-1:0] next_addr_reg;
    logic [WADDR_W-1:0] eval_addr_reg;

    logic [WORD_W-1:0]  first_mask;
    logic [WORD_W-1:0]  masked;
    logic [BIT_W-1:0]   enc;
    logic               found;

    // Lowest set bit by halving search
    function automatic logic [BIT_W-1:0] low_bit(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] v;
        logic [BIT_W-1:0]  p;
        v = w;
        p = '0;
        for (int s = BIT_W - 1; s >= 0; s--)
        begin
            if ((v & ((WORD_W'(1) << (1 << s)) - WORD_W'(1))) == '0)
            begin
                p[s] = 1'b1;
                v    = v >> (1 << s);
            end
        end
        return p;
    endfunction

    // Highest set bit by halving search
    function automatic logic [BIT_W-1:0] high_bit(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0] v;
        logic [BIT_W-1:0]  p;
        v = w;
        p = '0;
        for (int s = BIT_W - 1; s >= 0; s--)
        begin
            if ((v >> (1 << s)) != '0)
            begin
                p[s] = 1'b1;
                v    = v >> (1 << s);
            end
        end
        return p;
    endfunction

    // Advance one word in the scan direction, holding at the ends
    function automatic logic [WADDR_W-1:0] step(input logic [WADDR_W-1:0] a, input logic up);
        logic [WADDR_W-1:0] n;
        n = a;
        if (up)
        begin
            if (a != WADDR_W'(WORDS - 1))
            begin
                n = a + WADDR_W'(1);
            end
        end
        else
        begin
            if (a != '0)
            begin
                n = a - WADDR_W'(1);
            end
        end
        return n;
    endfunction

    // Mask off the bits behind the start point in the first word
    always_comb
    begin
        if (up_reg)
        begin
            first_mask = {WORD_W{1'b1}} << bit_reg;
        end
        else
        begin
            first_mask = {WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - bit_reg);
        end
        masked = first_reg ? (rdata & first_mask) : rdata;
        found  = active_reg && (masked != '0);
        enc    = up_reg ? low_bit(masked) : high_bit(masked);
    end

    assign res.found = found;
    assign res.pos   = IDX_W'({eval_addr_reg, enc});
    assign raddr     = cmd.start ? word_of(cmd.start_pos) : next_addr_reg;

    // Walk the words one read a cycle until a member turns up
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            up_reg        <= 1'b0;
            first_reg     <= 1'b0;
            bit_reg       <= '0;
            next_addr_reg <= '0;
            eval_addr_reg <= '0;
        end
        else if (cmd.start)
        begin
            active_reg    <= 1'b1;
            up_reg        <= cmd.up;
            first_reg     <= 1'b1;
            bit_reg       <= cmd.start_pos[BIT_W-1:0];
            eval_addr_reg <= word_of(cmd.start_pos);
            next_addr_reg <= step(word_of(cmd.start_pos), cmd.up);
        end
        else if (active_reg)
        begin
            if (found)
            begin
                active_reg <= 1'b0;
            end
            first_reg     <= 1'b0;
            eval_addr_reg <= next_addr_reg;
            next_addr_reg <= step(next_addr_reg, up_reg);
        end
    end

    `BIS_ASSERT_SAME(a_found_only_active, res.found, active_reg)
    `BIS_ASSERT_NEXT(a_start_activates, cmd.start, active_reg)
    `BIS_ASSERT_SAME(a_eval_in_range, active_reg, 32'(eval_addr_reg) < WORDS)

endmodule

### rtl/bitmap_index_set.sv
`timescale 1ns / 1ps
`include "bitmap_index_set_defines.svh"

// Set of indices over 0..1023 kept as a bitmap in a 16 x 64-bit RAM, with the
// lowest member, highest member and member count in registers. One request is
// taken at a time; each returns one result. Insert, remove of an inner member,
// contains, clear and unused codes pass through a read state and a done state
// before the next request. Next, prev and removal of an extreme may walk the
// bitmap one RAM word a cycle from the index towards the nearest member, reading
// 1 to 16 words. An interval load writes each covered word once (1 to 16 words).
// Reset and clear empty the bitmap at once through per-word valid flags; there
// is no clearing pass. The result register lets a new request in while the
// previous result waits.
module bitmap_index_set import bis_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,  // index[9:0], index_high[19:10], zero
    input  logic [OP_W-1:0]     s_tuser,  // op[2:0]
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,  // is_member[0], position[12:1],
                                          // lowest[22:13], highest[33:23],
                                          // member_count[44:34], zero
    output logic                m_tuser   // range_error[0]
);

    localparam int M_PAD_W = M_DATA_W - (1 + POS_W + IDX_W + HI_W + CNT_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_LOAD,
        ST_DONE
    } state_t;

    state_t                   state_reg;
    op_t                      op_reg;
    logic [IDX_W-1:0]         idx_reg;
    logic [IDX_W-1:0]         ihi_reg;
    logic [IDX_W-1:0]         lo_reg;
    logic signed [HI_W-1:0]   hi_reg;
    logic [CNT_W-1:0]         pop_reg;
    logic [WORDS-1:0]         word_valid_reg;
    logic [WADDR_W-1:0]       raddr_q;
    logic [WADDR_W-1:0]       load_addr_reg;
    logic                     member_reg;
    logic signed [POS_W-1:0]  pos_reg;
    logic                     err_reg;

    logic                     m_tvalid_reg;
    logic                     out_member_reg;
    logic signed [POS_W-1:0]  out_pos_reg;
    logic [IDX_W-1:0]         out_lo_reg;
    logic signed [HI_W-1:0]   out_hi_reg;
    logic [CNT_W-1:0]         out_cnt_reg;
    logic                     out_err_reg;

    logic                     member_next;
    logic signed [POS_W-1:0]  pos_next;
    logic                     err_next;
    state_t                   state_next;

    logic [IDX_W-1:0]         idx_in;
    logic [IDX_W-1:0]         ihi_in;
    logic [WADDR_W-1:0]       raddr;
    logic [WADDR_W-1:0]       scan_raddr;
    logic [WORD_W-1:0]        ram_rdata;
    logic [WORD_W-1:0]        rdata_eff;
    logic [WORD_W-1:0]        bit_mask;
    logic [WORD_W-1:0]        load_mask;
    logic [BIT_W-1:0]         load_lo_b;
    logic [BIT_W-1:0]         load_hi_b;
    logic                     wr_en;
    logic [WADDR_W-1:0]       wr_addr;
    logic [WORD_W-1:0]        wr_data;
    logic                     in_univ;
    logic                     ihi_univ;
    logic                     cur_bit;
    logic                     idx_lt_lo;
    logic                     idx_le_lo;
    logic                     idx_lt_hi;
    logic                     idx_gt_hi;
    logic                     rm_at_hi;
    logic                     rm_at_lo;
    scan_cmd_t                scan_cmd;
    scan_res_t                scan_res;

    function automatic logic in_universe(input logic [IDX_W-1:0] i);
        return 32'(i) < UNIVERSE;
    endfunction

    assign idx_in   = s_tdata[IDX_W-1:0];
    assign ihi_in   = s_tdata[2*IDX_W-1:IDX_W];
    assign s_tready = (state_reg == ST_IDLE);

    // Read the index word on request, otherwise follow the scanner
    assign raddr     = (state_reg == ST_IDLE) ? word_of(idx_in) : scan_raddr;
    assign rdata_eff = word_valid_reg[raddr_q] ? ram_rdata : '0;

    // Compare the index against the stored extremes
    always_comb
    begin
        bit_mask  = WORD_W'(1) << idx_reg[BIT_W-1:0];
        in_univ   = in_universe(idx_reg);
        ihi_univ  = in_universe(ihi_reg);
        cur_bit   = in_univ && rdata_eff[idx_reg[BIT_W-1:0]];
        idx_lt_lo = idx_reg < lo_reg;
        idx_le_lo = idx_reg <= lo_reg;
        idx_lt_hi = idx_reg < hi_reg[IDX_W-1:0];
        idx_gt_hi = idx_reg > hi_reg[IDX_W-1:0];
        rm_at_hi  = (pop_reg != CNT_W'(1)) && (hi_reg[IDX_W-1:0] == idx_reg);
        rm_at_lo  = (pop_reg != CNT_W'(1)) && (lo_reg == idx_reg) && !rm_at_hi;
    end

    // Result fields and follow-on state decided in the read cycle
    always_comb
    begin
        member_next = cur_bit;
        pos_next    = POS_W'(idx_reg);
        err_next    = 1'b0;
        state_next  = ST_DONE;
        case (op_reg)
            OP_INSERT:
            begin
                if (!in_univ)
                begin
                    err_next = 1'b1;
                end
                else
                begin
                    member_next = 1'b1;
                end
            end
            OP_REMOVE:
            begin
                if (cur_bit)
                begin
                    member_next = 1'b0;
                    if (rm_at_hi || rm_at_lo)
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            OP_NEXT:
            begin
                if ((pop_reg == '0) || !idx_lt_hi)
                begin
                    pos_next = POS_W'(idx_reg) + POS_W'(1);
                end
                else if (idx_lt_lo)
                begin
                    pos_next = POS_W'(lo_reg);
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            OP_PREV:
            begin
                if (pop_reg == '0)
                begin
                    pos_next = POS_W'(idx_reg) - POS_W'(1);
                end
                else if (idx_gt_hi)
                begin
                    pos_next = POS_W'(hi_reg);
                end
                else if (idx_le_lo)
                begin
                    pos_next = POS_W'(idx_reg) - POS_W'(1);
                end
                else
                begin
                    state_next = ST_SCAN;
                end
            end
            OP_CLEAR:
            begin
                member_next = 1'b0;
            end
            OP_LOAD:
            begin
                if (!in_univ || !ihi_univ)
                begin
                    err_next = 1'b1;
                end
                else if (ihi_reg >= idx_reg)
                begin
                    member_next = 1'b1;
                    state_next  = ST_LOAD;
                end
                else
                begin
                    member_next = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Interval bits that fall in the word being loaded
    always_comb
    begin
        load_lo_b = (load_addr_reg == word_of(idx_reg)) ? idx_reg[BIT_W-1:0] : '0;
        load_hi_b = (load_addr_reg == word_of(ihi_reg)) ? ihi_reg[BIT_W-1:0]
                                                        : BIT_W'(WORD_W - 1);
        load_mask = ({WORD_W{1'b1}} << load_lo_b)
                  & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - load_hi_b));
    end

    // RAM write-back and scan start
    always_comb
    begin
        wr_en              = 1'b0;
        wr_addr            = word_of(idx_reg);
        wr_data            = rdata_eff | bit_mask;
        scan_cmd.start     = 1'b0;
        scan_cmd.up        = 1'b1;
        scan_cmd.start_pos = idx_reg + IDX_W'(1);
        case (state_reg)
            ST_READ:
            begin
                case (op_reg)
                    OP_INSERT:
                    begin
                        wr_en = in_univ;
                    end
                    OP_REMOVE:
                    begin
                        wr_en   = cur_bit;
                        wr_data = rdata_eff & ~bit_mask;
                        if (cur_bit && rm_at_hi)
                        begin
                            scan_cmd.start     = 1'b1;
                            scan_cmd.up        = 1'b0;
                            scan_cmd.start_pos = idx_reg - IDX_W'(1);
                        end
                        else if (cur_bit && rm_at_lo)
                        begin
                            scan_cmd.start = 1'b1;
                        end
                    end
                    OP_NEXT:
                    begin
                        scan_cmd.start = (pop_reg != '0) && idx_lt_hi && !idx_lt_lo;
                    end
                    OP_PREV:
                    begin
                        scan_cmd.start     = (pop_reg != '0) && !idx_gt_hi && !idx_le_lo;
                        scan_cmd.up        = 1'b0;
                        scan_cmd.start_pos = idx_reg - IDX_W'(1);
                    end
                    default:
                    begin
                    end
                endcase
            end
            ST_LOAD:
            begin
                wr_en   = 1'b1;
                wr_addr = load_addr_reg;
                wr_data = load_mask;
            end
            default:
            begin
            end
        endcase
    end

    bis_ram #(
        .WIDTH (WORD_W),
        .DEPTH (WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (raddr),
        .rdata (ram_rdata)
    );

    bis_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (scan_cmd),
        .rdata (rdata_eff),
        .raddr (scan_raddr),
        .res   (scan_res)
    );

    // Sequencer, set summary and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_CONTAINS;
            idx_reg        <= '0;
            ihi_reg        <= '0;
            lo_reg         <= '0;
            hi_reg         <= '1;
            pop_reg        <= '0;
            word_valid_reg <= '0;
            raddr_q        <= '0;
            load_addr_reg  <= '0;
            member_reg     <= 1'b0;
            pos_reg        <= '0;
            err_reg        <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            out_member_reg <= 1'b0;
            out_pos_reg    <= '0;
            out_lo_reg     <= '0;
            out_hi_reg     <= '0;
            out_cnt_reg    <= '0;
            out_err_reg    <= 1'b0;
        end
        else
        begin
            raddr_q <= raddr;
            // Drop the result once taken, unless a new one is loaded now
            if (m_tvalid_reg && m_tready && (state_reg != ST_DONE))
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg    <= op_t'(s_tuser);
                        idx_reg   <= idx_in;
                        ihi_reg   <= ihi_in;
                        state_reg <= ST_READ;
                    end
                end
                ST_READ:
                begin
                    member_reg <= member_next;
                    pos_reg    <= pos_next;
                    err_reg    <= err_next;
                    state_reg  <= state_next;
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (in_univ)
                            begin
                                word_valid_reg[raddr_q]   <= 1'b1;
                                if (pop_reg == '0)
                                begin
                                    lo_reg  <= idx_reg;
                                    hi_reg  <= HI_W'(idx_reg);
                                    pop_reg <= CNT_W'(1);
                                end
                                else
                                begin
                                    if (idx_gt_hi)
                                    begin
                                        hi_reg <= HI_W'(idx_reg);
                                    end
                                    if (idx_lt_lo)
                                    begin
                                        lo_reg <= idx_reg;
                                    end
                                    if (!cur_bit)
                                    begin
                                        pop_reg <= pop_reg + CNT_W'(1);
                                    end
                                end
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (cur_bit)
                            begin
                                if (pop_reg == CNT_W'(1))
                                begin
                                    lo_reg  <= '0;
                                    hi_reg  <= '1;
                                    pop_reg <= '0;
                                end
                                else if (!rm_at_hi && !rm_at_lo)
                                begin
                                    pop_reg <= pop_reg - CNT_W'(1);
                                end
                            end
                        end
                        OP_CLEAR:
                        begin
                            word_valid_reg <= '0;
                            lo_reg         <= '0;
                            hi_reg         <= '1;
                            pop_reg        <= '0;
                        end
                        OP_LOAD:
                        begin
                            if (in_univ && ihi_univ)
                            begin
                                word_valid_reg <= '0;
                                if (ihi_reg >= idx_reg)
                                begin
                                    lo_reg        <= idx_reg;
                                    hi_reg        <= HI_W'(ihi_reg);
                                    pop_reg       <= CNT_W'(ihi_reg) - CNT_W'(idx_reg)
                                                   + CNT_W'(1);
                                    load_addr_reg <= word_of(idx_reg);
                                end
                                else
                                begin
                                    lo_reg  <= '0;
                                    hi_reg  <= '1;
                                    pop_reg <= '0;
                                end
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
                ST_SCAN:
                begin
                    if (scan_res.found)
                    begin
                        if (op_reg == OP_REMOVE)
                        begin
                            if (rm_at_hi)
                            begin
                                hi_reg <= HI_W'(scan_res.pos);
                            end
                            else
                            begin
                                lo_reg <= scan_res.pos;
                            end
                            pop_reg <= pop_reg - CNT_W'(1);
                        end
                        else
                        begin
                            pos_reg <= POS_W'(scan_res.pos);
                        end
                        state_reg <= ST_DONE;
                    end
                end
                ST_LOAD:
                begin
                    word_valid_reg[load_addr_reg] <= 1'b1;
                    if (load_addr_reg == word_of(ihi_reg))
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        load_addr_reg <= load_addr_reg + WADDR_W'(1);
                    end
                end
                ST_DONE:
                begin
                    if (!m_tvalid_reg || m_tready)
                    begin
                        out_member_reg <= member_reg;
                        out_pos_reg    <= pos_reg;
                        out_lo_reg     <= lo_reg;
                        out_hi_reg     <= hi_reg;
                        out_cnt_reg    <= pop_reg;
                        out_err_reg    <= err_reg;
                        m_tvalid_reg   <= 1'b1;
                        state_reg      <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_err_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_cnt_reg, out_hi_reg, out_lo_reg,
                       out_pos_reg, out_member_reg};

    `BIS_ASSERT_SAME(a_empty_extremes, pop_reg == '0, (hi_reg == '1) && (lo_reg == '0))
    `BIS_ASSERT_SAME(a_extremes_order, pop_reg != '0, !hi_reg[HI_W-1] && (lo_reg <= hi_reg[IDX_W-1:0]))
    `BIS_ASSERT_SAME(a_no_write_in_scan, state_reg == ST_SCAN, !wr_en)

endmodule
